[hw/rtl/pfd_pkg.sv]
// Shared types, constants and helpers for the filtered-derivative PID block.
`default_nettype none
package pfd_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned US_PER_S = 1000000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_GAIN_P      = 3'd0,
    REG_GAIN_I      = 3'd1,
    REG_GAIN_D      = 3'd2,
    REG_INTEG_LIMIT = 3'd3,
    REG_FILTER_US   = 3'd4,
    REG_STALE_US    = 3'd5
  } pfd_reg_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLEAR,
    OP_MUL_P,
    OP_MUL_I,
    OP_TSAT,
    OP_MUL_IDT,
    OP_DIV_I,
    OP_INTEG,
    OP_MUL_DLT,
    OP_MUL_DD,
    OP_DIV_D,
    OP_DUPD,
    OP_MUL_DG,
    OP_DTERM,
    OP_FIRST
  } pfd_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_I,
    ST_TSAT,
    ST_MUL_IDT,
    ST_DIV_I,
    ST_DIV_I_WAIT,
    ST_INTEG,
    ST_MUL_DLT,
    ST_MUL_DD,
    ST_DIV_D,
    ST_DIV_D_WAIT,
    ST_DUPD,
    ST_MUL_DG,
    ST_DTERM,
    ST_EMIT
  } pfd_state_e;

  typedef struct packed {
    pfd_op_e op;
    logic    emit;     // write regular result to output register
    logic    first;    // write P-only result and re-arm
  } pfd_cmd_t;

  typedef struct packed {
    logic stale;
    logic dt_zero;
    logic div_busy;
    logic out_busy;
  } pfd_stat_t;

  function automatic logic [31:0] sat32(input logic signed [65:0] v);
    logic [31:0] r;
    if (v > 66'sh0_0000_0000_7fff_ffff) begin
      r = 32'h7fff_ffff;
    end else if (v < -66'sh0_0000_0000_8000_0000) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/pid_filtered_derivative.sv]
// PID controller with low-pass filtered derivative, top level.
// Takes one request at a time: an error sample with a microsecond timestamp, or a
// clear command (tuser set) that is absorbed in idle with no result. A first
// or stale sample returns only the P term, through MUL_P, MUL_I, TSAT and EMIT.
// A regular update walks one shared 33x33 multiplier, a digit-by-digit divide
// of the integrand by one million and a radix-2 divider for the derivative
// step, which is skipped when the time step is zero. The result waits in an
// output register; the next request is taken as soon as the sequencer is back
// in idle. Configuration writes are taken at any time, and are meant to happen
// only while no update is in flight.
`default_nettype none
module pid_filtered_derivative
  import pfd_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [63:0]        s_axis_tdata,   // error_in[31:0], time_us[63:32]
  input  wire logic [0:0]         s_axis_tuser,   // cmd[0]
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [31:0]             m_axis_tdata,   // drive[31:0]
  output logic [0:0]              m_axis_tuser    // p_only[0]
);

  pfd_cmd_t  cmd;
  pfd_stat_t stat;

  pfd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_clear_i (s_axis_tuser[0]),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pfd_dpath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .error_i     (s_axis_tdata[31:0]),
    .time_i      (s_axis_tdata[63:32]),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_drive_o (m_axis_tdata),
    .out_ponly_o (m_axis_tuser[0])
  );

endmodule
`default_nettype wire

[hw/rtl/pfd_div.sv]
// Radix-2 restoring divider, signed 64-bit dividend by unsigned 33-bit divisor.
`default_nettype none
module pfd_div
  import pfd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [63:0] dividend_i,
  input  wire logic        [32:0] divisor_i,
  output logic                    busy_o,
  output logic signed [63:0]      quotient_o
);

  logic        busy_q, busy_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        neg_q, neg_d;
  logic [32:0] div_q, div_d;
  logic [32:0] rem_q, rem_d;
  logic [63:0] quo_q, quo_d;
  logic [33:0] rem_sh;
  logic        ge;

  assign rem_sh = {rem_q, quo_q[63]};
  assign ge     = rem_sh >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    div_d  = div_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 7'd64;
      neg_d  = dividend_i[63];
      div_d  = divisor_i;
      rem_d  = '0;
      quo_d  = dividend_i[63] ? 64'(-dividend_i) : dividend_i;
    end else if (busy_q) begin
      rem_d = ge ? 33'(rem_sh - {1'b0, div_q}) : rem_sh[32:0];
      quo_d = {quo_q[62:0], ge};
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    div_q <= div_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule
`default_nettype wire

[hw/rtl/pfd_dpath.sv]
// Datapath: config registers, controller state, shared multiplier, dividers, output register.
`default_nettype none
module pfd_dpath
  import pfd_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire logic [31:0]        error_i,
  input  wire logic [31:0]        time_i,
  input  wire pfd_cmd_t           cmd_i,
  output pfd_stat_t               stat_o,
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  output logic [31:0]             out_drive_o,
  output logic                    out_ponly_o
);

  // configuration
  logic [31:0] gain_p_q, gain_i_q, gain_d_q, rc_q, stale_q;
  logic [30:0] lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q <= '0;
      gain_i_q <= '0;
      gain_d_q <= '0;
      lim_q    <= '0;
      rc_q     <= 32'd1000;
      stale_q  <= 32'd100000;
    end else if (cfg_we_i) begin
      case (pfd_reg_e'(cfg_idx_i))
        REG_GAIN_P:      gain_p_q <= cfg_data_i;
        REG_GAIN_I:      gain_i_q <= cfg_data_i;
        REG_GAIN_D:      gain_d_q <= cfg_data_i;
        REG_INTEG_LIMIT: lim_q    <= cfg_data_i[30:0];
        REG_FILTER_US:   rc_q     <= cfg_data_i;
        REG_STALE_US:    stale_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // controller state
  logic        [31:0] integ_q, integ_d;
  logic        [31:0] perr_q, perr_d;
  logic        [31:0] fd_q, fd_d;
  logic        [31:0] ptime_q, ptime_d;
  logic               primed_q, primed_d;
  // per-sample working registers
  logic        [31:0] err_q, err_d, now_q, now_d, dt_q, dt_d, t_q, t_d;
  logic signed [63:0] pterm_q, pterm_d, dterm_q, dterm_d, numa_q, numa_d;
  logic signed [65:0] prod_q, prod_d;
  logic               out_valid_q, out_valid_d, out_ponly_q, out_ponly_d;
  logic        [31:0] out_drive_q, out_drive_d;

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic               mul_en;
  logic signed [32:0] delta;

  assign delta = $signed({err_q[31], err_q}) - $signed({perr_q[31], perr_q});

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (cmd_i.op)
      OP_MUL_P:   begin mul_a = $signed({gain_p_q[31], gain_p_q});
                        mul_b = $signed({err_q[31], err_q}); end
      OP_MUL_I:   begin mul_a = $signed({gain_i_q[31], gain_i_q});
                        mul_b = $signed({err_q[31], err_q}); end
      OP_MUL_IDT: begin mul_a = $signed({t_q[31], t_q});
                        mul_b = $signed({1'b0, dt_q}); end
      OP_MUL_DLT: begin mul_a = delta;
                        mul_b = 33'(US_PER_S); end
      OP_MUL_DD:  begin mul_a = $signed({1'b0, dt_q});
                        mul_b = $signed({fd_q[31], fd_q}); end
      OP_MUL_DG:  begin mul_a = $signed({gain_d_q[31], gain_d_q});
                        mul_b = $signed({fd_q[31], fd_q}); end
      default:    mul_en = 1'b0;
    endcase
  end

  assign prod_d = mul_en ? mul_a * mul_b : prod_q;

  // divider for the derivative step
  logic               div_start, div_busy;
  logic signed [63:0] quo;
  logic        [32:0] div_den;
  logic signed [64:0] num_diff;
  logic signed [63:0] num_sat;

  assign num_diff = $signed({numa_q[63], numa_q}) - $signed({prod_q[63], prod_q[63:0]});
  assign num_sat  = (num_diff[64] != num_diff[63])
                  ? (num_diff[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}})
                  : num_diff[63:0];

  assign div_start = (cmd_i.op == OP_DIV_D);
  assign div_den   = {1'b0, dt_q} + {1'b0, rc_q};

  pfd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (num_sat),
    .divisor_i  (div_den),
    .busy_o     (div_busy),
    .quotient_o (quo)
  );

  // integrand / 1e6: long division in 12-bit digits on the magnitude; each
  // digit comes from a reciprocal multiply, then the remainder is reduced
  localparam logic [26:0] UsRecip = 27'd70368745;  // ceil(2^40 / 15625)

  logic               c_busy_q, c_busy_d;
  logic               c_phase_q, c_phase_d;  // 0: estimate digit, 1: reduce
  logic        [2:0]  c_cnt_q, c_cnt_d;
  logic               c_neg_q, c_neg_d;
  logic        [71:0] c_num_q, c_num_d;
  logic        [19:0] c_rem_q, c_rem_d;
  logic        [11:0] c_dig_q, c_dig_d;
  logic        [63:0] c_quo_q, c_quo_d;
  logic        [31:0] c_part, c_sub, c_red;
  logic        [52:0] c_est;
  logic signed [63:0] c_quo;

  assign c_part = {c_rem_q, c_num_q[71:60]};
  assign c_est  = c_part[31:6] * UsRecip;
  assign c_sub  = {20'd0, c_dig_q} * 32'(US_PER_S);
  assign c_red  = c_part - c_sub;
  assign c_quo  = c_neg_q ? -$signed(c_quo_q) : $signed(c_quo_q);

  always_comb begin
    c_busy_d  = c_busy_q;
    c_phase_d = c_phase_q;
    c_cnt_d   = c_cnt_q;
    c_neg_d   = c_neg_q;
    c_num_d   = c_num_q;
    c_rem_d   = c_rem_q;
    c_dig_d   = c_dig_q;
    c_quo_d   = c_quo_q;
    if (cmd_i.op == OP_DIV_I) begin
      c_busy_d  = 1'b1;
      c_phase_d = 1'b0;
      c_cnt_d   = 3'd6;
      c_neg_d   = prod_q[63];
      c_num_d   = {8'd0, (prod_q[63] ? 64'(-prod_q[63:0]) : prod_q[63:0])};
      c_rem_d   = '0;
      c_quo_d   = '0;
    end else if (c_busy_q) begin
      if (!c_phase_q) begin
        c_dig_d   = c_est[51:40];
        c_phase_d = 1'b1;
      end else begin
        c_rem_d   = c_red[19:0];
        c_num_d   = {c_num_q[59:0], 12'd0};
        c_quo_d   = {c_quo_q[51:0], c_dig_q};
        c_phase_d = 1'b0;
        c_cnt_d   = c_cnt_q - 3'd1;
        if (c_cnt_q == 3'd1) begin
          c_busy_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_busy_q  <= 1'b0;
      c_phase_q <= 1'b0;
      c_cnt_q   <= '0;
    end else begin
      c_busy_q  <= c_busy_d;
      c_phase_q <= c_phase_d;
      c_cnt_q   <= c_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_neg_q <= c_neg_d;
    c_num_q <= c_num_d;
    c_rem_q <= c_rem_d;
    c_dig_q <= c_dig_d;
    c_quo_q <= c_quo_d;
  end

  // arithmetic helpers
  logic signed [65:0] prod_sh;
  logic signed [65:0] integ_sum, fd_sum, total;
  logic        [31:0] acc;
  logic signed [32:0] lim_pos, lim_neg;

  assign prod_sh   = prod_q >>> FRAC_BITS;
  assign integ_sum = 66'($signed(integ_q)) + 66'(c_quo);
  assign fd_sum    = 66'($signed(fd_q)) + 66'(quo);
  assign total     = 66'(pterm_q) + 66'($signed(integ_q)) + 66'(dterm_q);
  assign acc       = sat32(integ_sum);
  assign lim_pos   = $signed({2'b00, lim_q});
  assign lim_neg   = -lim_pos;

  always_comb begin
    integ_d     = integ_q;
    perr_d      = perr_q;
    fd_d        = fd_q;
    ptime_d     = ptime_q;
    primed_d    = primed_q;
    err_d       = err_q;
    now_d       = now_q;
    dt_d        = dt_q;
    t_d         = t_q;
    pterm_d     = pterm_q;
    dterm_d     = dterm_q;
    numa_d      = numa_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_drive_d = out_drive_q;
    out_ponly_d = out_ponly_q;
    case (cmd_i.op)
      OP_LOAD: begin
        err_d   = error_i;
        now_d   = time_i;
        dt_d    = time_i - ptime_q;
        dterm_d = '0;
      end
      OP_CLEAR: begin
        integ_d  = '0;
        perr_d   = '0;
        fd_d     = '0;
        ptime_d  = '0;
        primed_d = 1'b0;
      end
      OP_MUL_I:  pterm_d = prod_sh[63:0];
      OP_TSAT:   t_d     = sat32(prod_sh);
      OP_INTEG: begin
        ptime_d = now_q;
        if ($signed({acc[31], acc}) > lim_pos) begin
          integ_d = lim_pos[31:0];
        end else if ($signed({acc[31], acc}) < lim_neg) begin
          integ_d = lim_neg[31:0];
        end else begin
          integ_d = acc;
        end
      end
      OP_MUL_DD: numa_d  = prod_q[63:0];
      OP_DUPD:   fd_d    = sat32(fd_sum);
      OP_DTERM:  dterm_d = prod_sh[63:0];
      default: ;
    endcase
    if (cmd_i.first) begin
      integ_d     = '0;
      fd_d        = '0;
      ptime_d     = now_q;
      perr_d      = err_q;
      primed_d    = 1'b1;
      out_valid_d = 1'b1;
      out_drive_d = sat32(66'(pterm_q));
      out_ponly_d = 1'b1;
    end
    if (cmd_i.emit) begin
      perr_d      = err_q;
      out_valid_d = 1'b1;
      out_drive_d = sat32(total);
      out_ponly_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q     <= '0;
      perr_q      <= '0;
      fd_q        <= '0;
      ptime_q     <= '0;
      primed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      integ_q     <= integ_d;
      perr_q      <= perr_d;
      fd_q        <= fd_d;
      ptime_q     <= ptime_d;
      primed_q    <= primed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    err_q       <= err_d;
    now_q       <= now_d;
    dt_q        <= dt_d;
    t_q         <= t_d;
    pterm_q     <= pterm_d;
    dterm_q     <= dterm_d;
    numa_q      <= numa_d;
    prod_q      <= prod_d;
    out_drive_q <= out_drive_d;
    out_ponly_q <= out_ponly_d;
  end

  assign stat_o.stale    = !primed_q || (dt_q > stale_q);
  assign stat_o.dt_zero  = (dt_q == '0);
  assign stat_o.div_busy = div_busy || c_busy_q;
  assign stat_o.out_busy = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_drive_o = out_drive_q;
  assign out_ponly_o = out_ponly_q;

endmodule
`default_nettype wire

[hw/rtl/pfd_ctrl.sv]
// Sequencer that steps the datapath through one PID update.
`default_nettype none
module pfd_ctrl
  import pfd_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      in_clear_i,
  output logic           in_ready_o,
  input  wire pfd_stat_t stat_i,
  output pfd_cmd_t       cmd_o
);

  pfd_state_e state_q, state_d;
  logic       first_q, first_d;   // emit pending is the P-only result

  always_comb begin
    state_d = state_q;
    first_d = first_q;
    case (state_q)
      ST_IDLE:       if (in_valid_i && !in_clear_i) state_d = ST_MUL_P;
      ST_MUL_P:      state_d = ST_MUL_I;
      ST_MUL_I:      state_d = ST_TSAT;
      ST_TSAT: begin
        first_d = stat_i.stale;
        state_d = stat_i.stale ? ST_EMIT : ST_MUL_IDT;
      end
      ST_MUL_IDT:    state_d = ST_DIV_I;
      ST_DIV_I:      state_d = ST_DIV_I_WAIT;
      ST_DIV_I_WAIT: if (!stat_i.div_busy) state_d = ST_INTEG;
      ST_INTEG:      state_d = stat_i.dt_zero ? ST_EMIT : ST_MUL_DLT;
      ST_MUL_DLT:    state_d = ST_MUL_DD;
      ST_MUL_DD:     state_d = ST_DIV_D;
      ST_DIV_D:      state_d = ST_DIV_D_WAIT;
      ST_DIV_D_WAIT: if (!stat_i.div_busy) state_d = ST_DUPD;
      ST_DUPD:       state_d = ST_MUL_DG;
      ST_MUL_DG:     state_d = ST_DTERM;
      ST_DTERM:      state_d = ST_EMIT;
      ST_EMIT:       if (!stat_i.out_busy) state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '{op: OP_NONE, emit: 1'b0, first: 1'b0};
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = in_clear_i ? OP_CLEAR : OP_LOAD;
      end
      ST_MUL_P:   cmd_o.op = OP_MUL_P;
      ST_MUL_I:   cmd_o.op = OP_MUL_I;
      ST_TSAT:    cmd_o.op = OP_TSAT;
      ST_MUL_IDT: cmd_o.op = OP_MUL_IDT;
      ST_DIV_I:   cmd_o.op = OP_DIV_I;
      ST_INTEG:   cmd_o.op = OP_INTEG;
      ST_MUL_DLT: cmd_o.op = OP_MUL_DLT;
      ST_MUL_DD:  cmd_o.op = OP_MUL_DD;
      ST_DIV_D:   cmd_o.op = OP_DIV_D;
      ST_DUPD:    cmd_o.op = OP_DUPD;
      ST_MUL_DG:  cmd_o.op = OP_MUL_DG;
      ST_DTERM:   cmd_o.op = OP_DTERM;
      ST_EMIT: begin
        cmd_o.first = !stat_i.out_busy && first_q;
        cmd_o.emit  = !stat_i.out_busy && !first_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      first_q <= first_d;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/pfd_checker.sv]
// Port-level checks for the PID block, bound to the top level.
`default_nettype none
module pfd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [0:0]  s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata
);

  // an update request occupies the sequencer
  a_busy_after_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !s_axis_tuser[0] |=> !s_axis_tready)
    else $error("ready after update request");

  // no result can appear in the cycle right after a request
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result too early");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output changed while stalled");

endmodule

bind pid_filtered_derivative pfd_checker u_pfd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

[tb/tb_pid_filtered_derivative.sv]
// Testbench for the filtered-derivative PID block: directed and random updates, checked against a predictor.
`default_nettype none
module tb_pid_filtered_derivative;
  import pfd_pkg::*;

  localparam int unsigned FracBits = 16;
  localparam int unsigned WatchLimit = 20000;
  localparam int unsigned DrainCycles = 300;
  localparam bit CmdUpdate = 1'b0;
  localparam bit CmdClear = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [31:0] err;
    logic [31:0] tstamp;
  } sample_t;

  typedef struct packed {
    logic [31:0] drive;
    logic        p_only;
  } drive_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [0:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;

  pid_filtered_derivative #(.FRAC_BITS(FracBits)) u_top (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // predictor copy of registers and state
  logic signed [31:0] kp, ki, kd;
  logic [30:0] ilim;
  logic [31:0] rc_us, stale_us;
  logic signed [31:0] integ, prev_err, dfilt;
  logic [31:0] prev_t;
  logic primed;

  sample_t pending_q[$];
  drive_t drive_q[$];
  int errors = 0;
  int n_updates = 0, n_clears = 0, n_ponly = 0, n_results = 0;
  bit quiet = 1'b0;
  int unsigned idle_cnt = 0;

  function automatic longint fshift(longint v);
    return v >>> FracBits;
  endfunction

  function automatic logic signed [31:0] sat(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic void clear_ctl();
    integ = 0; prev_err = 0; dfilt = 0; prev_t = 0; primed = 1'b0;
  endfunction

  // returns 1 and the drive value for an update, 0 for a clear
  function automatic bit predict_drive(sample_t s, output drive_t r);
    longint e, pt, tot, t, inc, acc, lim, dlt, num, den, prod;
    logic [31:0] dt;
    e = longint'($signed(s.err));
    if (s.cmd == CmdClear) begin
      clear_ctl();
      return 1'b0;
    end
    pt = fshift(longint'(kp) * e);
    dt = s.tstamp - prev_t;
    if (!primed || dt > stale_us) begin
      integ = 0; dfilt = 0; prev_t = s.tstamp; prev_err = s.err; primed = 1'b1;
      r.drive = sat(pt); r.p_only = 1'b1;
      return 1'b1;
    end
    prev_t = s.tstamp;
    lim = longint'(ilim);
    t = sat(fshift(longint'(ki) * e));
    inc = (t * longint'({32'd0, dt})) / 1000000;
    acc = sat(longint'(integ) + inc);
    if (acc > lim) acc = lim;
    if (acc < -lim) acc = -lim;
    integ = acc[31:0];
    tot = pt + longint'(integ);
    if (dt != 0) begin
      dlt = e - longint'(prev_err);
      prod = longint'({32'd0, dt}) * longint'(dfilt);
      num = dlt * 1000000 - prod;
      // saturating 64-bit subtract
      if (prod < 0 && dlt * 1000000 > 64'sh7fffffffffffffff + prod) num = 64'sh7fffffffffffffff;
      if (prod > 0 && dlt * 1000000 < 64'sh8000000000000000 + prod) num = 64'sh8000000000000000;
      den = longint'({32'd0, dt}) + longint'({32'd0, rc_us});
      dfilt = sat(longint'(dfilt) + num / den);
      tot += fshift(longint'(kd) * longint'(dfilt));
    end
    prev_err = s.err;
    r.drive = sat(tot); r.p_only = 1'b0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  // driver with random idle bursts
  int unsigned s_gap = 0;
  always @(posedge clk_i) begin
    sample_t s;
    drive_t r;
    if (s_axis_tvalid && s_axis_tready) begin
      s = {s_axis_tuser[0], s_axis_tdata[31:0], s_axis_tdata[63:32]};
      if (predict_drive(s, r)) drive_q.push_back(r);
      if (s.cmd == CmdClear) n_clears++; else n_updates++;
    end
    if (!s_axis_tvalid || s_axis_tready) begin
      if (s_gap > 0) begin
        s_gap <= s_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        s = pending_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {s.tstamp, s.err};
        s_axis_tuser <= s.cmd;
        if (!quiet && $urandom_range(0, 3) == 0) s_gap <= $urandom_range(1, 11);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor with random stall bursts
  int unsigned m_gap = 0;
  always @(posedge clk_i) begin
    drive_t w;
    if (m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (drive_q.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata, 32'd0);
      end else begin
        w = drive_q.pop_front();
        if (m_axis_tdata !== w.drive) report_mismatch("drive", m_axis_tdata, w.drive);
        if (m_axis_tuser[0] !== w.p_only) report_mismatch("p_only", m_axis_tuser, w.p_only);
        if (w.p_only) n_ponly++;
      end
    end
    if (m_gap > 0) begin
      m_gap <= m_gap - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (!quiet && $urandom_range(0, 5) == 0) m_gap <= $urandom_range(1, 11);
    end
  end

  // watchdog: cycles with no handshake on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cnt <= 0;
    end else if (rst_ni && (pending_q.size() > 0 || drive_q.size() > 0 || s_axis_tvalid)) begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WatchLimit) begin
        $display("Watchdog expired, no traffic");
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic write_reg(pfd_reg_e idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_GAIN_P: kp = val;
      REG_GAIN_I: ki = val;
      REG_GAIN_D: kd = val;
      REG_INTEG_LIMIT: ilim = val[30:0];
      REG_FILTER_US: rc_us = val;
      default: stale_us = val;
    endcase
  endtask

  task automatic wait_idle();
    while (pending_q.size() > 0 || s_axis_tvalid || drive_q.size() > 0) @(posedge clk_i);
    // a trailing clear has no result; allow the sequencer to settle
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rnd_err();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom();
      default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    endcase
  endfunction

  function automatic logic [31:0] rnd_gain();
    case ($urandom_range(0, 4))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom();
      default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    endcase
  endfunction

  initial begin
    sample_t s;
    logic [31:0] tnow;
    kp = 0; ki = 0; kd = 0; ilim = 0; rc_us = 1000; stale_us = 100000;
    clear_ctl();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: defaults first, then extremes
    pending_q.push_back('{CmdUpdate, 32'h0001_0000, 32'd100});
    pending_q.push_back('{CmdUpdate, 32'h0002_0000, 32'd200});
    wait_idle();
    write_reg(REG_GAIN_P, 32'h0001_0000);
    write_reg(REG_GAIN_I, 32'h0002_0000);
    write_reg(REG_GAIN_D, 32'h0000_8000);
    write_reg(REG_INTEG_LIMIT, 32'h7fffffff);
    write_reg(REG_FILTER_US, 32'd500);
    write_reg(REG_STALE_US, 32'd50000);
    pending_q.push_back('{CmdUpdate, 32'h0001_0000, 32'd1000});  // regular update; primed by the default samples
    pending_q.push_back('{CmdUpdate, 32'h0003_0000, 32'd2000});
    pending_q.push_back('{CmdUpdate, 32'h0004_0000, 32'd2000});  // zero time step
    pending_q.push_back('{CmdUpdate, 32'h7fffffff, 32'd3000});
    pending_q.push_back('{CmdUpdate, 32'h80000000, 32'd4000});
    pending_q.push_back('{CmdUpdate, 32'h0, 32'd54001});         // stale
    pending_q.push_back('{CmdUpdate, 32'h0, 32'hffff_fff0});     // stale, then wrap
    pending_q.push_back('{CmdUpdate, 32'h1234, 32'h0000_0010});
    pending_q.push_back('{CmdClear, 32'hffffffff, 32'hffffffff});
    pending_q.push_back('{CmdUpdate, 32'hffff_0000, 32'd77});
    wait_idle();
    write_reg(REG_GAIN_P, 32'h7fffffff);
    write_reg(REG_GAIN_I, 32'h80000000);
    write_reg(REG_GAIN_D, 32'h7fffffff);
    write_reg(REG_INTEG_LIMIT, 32'd0);
    write_reg(REG_FILTER_US, 32'd0);
    write_reg(REG_STALE_US, 32'hffffffff);
    pending_q.push_back('{CmdUpdate, 32'h80000000, 32'd0});
    pending_q.push_back('{CmdUpdate, 32'h7fffffff, 32'd1});
    pending_q.push_back('{CmdUpdate, 32'h80000000, 32'hffffffff});
    pending_q.push_back('{CmdUpdate, 32'h7fffffff, 32'hfffffffe});
    pending_q.push_back('{CmdUpdate, 32'h0, 32'hfffffffe});
    wait_idle();

    // random phases, each with fresh settings
    for (int ph = 0; ph < 14; ph++) begin
      write_reg(REG_GAIN_P, rnd_gain());
      write_reg(REG_GAIN_I, rnd_gain());
      write_reg(REG_GAIN_D, rnd_gain());
      write_reg(REG_INTEG_LIMIT, ($urandom_range(0, 2) == 0) ? $urandom() : $urandom_range(0, 32'h0040_0000));
      write_reg(REG_FILTER_US, ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 5000));
      write_reg(REG_STALE_US, ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 20000));
      if (ph == 13) quiet = 1'b1;
      tnow = $urandom();
      for (int k = 0; k < 72; k++) begin
        s.cmd = ($urandom_range(0, 24) == 0) ? CmdClear : CmdUpdate;
        s.err = rnd_err();
        case ($urandom_range(0, 9))
          0: tnow = tnow;
          1: tnow = tnow + $urandom_range(10000, 200000);
          2: tnow = $urandom();
          default: tnow = tnow + $urandom_range(1, 3000);
        endcase
        s.tstamp = tnow;
        pending_q.push_back(s);
      end
      wait_idle();
    end

    $display("Covered %0d updates and %0d clears; %0d results, %0d proportional-only.",
             n_updates, n_clears, n_results, n_ponly);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire
